// ===== hdl/war_pkg.sv =====
// ----------------------------------------------------------------------------
// war_pkg
// Shared widths, register indexes, datapath op codes and the control/status
// bundles between the weighted anchor refine controller and datapath.
// ----------------------------------------------------------------------------
package war_pkg;

	localparam int COORD_W = 32;   // Q15.16 coordinate
	localparam int ACC_W   = 64;   // weighted position sums, 32 fraction bits
	localparam int WT_W    = 40;   // weight total, Q.16
	localparam int CONF_W  = 17;   // Q1.16 confidence / blend
	localparam int RAD_W   = 31;   // radius, unsigned Q15.16
	localparam int W_W     = 20;   // one vertex weight, at most 2^32 / 6554
	localparam int MUL_W   = 33;   // shared multiplier operand width
	localparam int IDX_W   = 3;    // config register index

	localparam logic [CONF_W-1:0] ONE_Q16   = 17'd65536;
	localparam logic [15:0]       TENTH_Q16 = 16'd6554;

	// Config register indexes
	localparam logic [IDX_W-1:0] CFG_ANCHOR_X = 3'd0;
	localparam logic [IDX_W-1:0] CFG_ANCHOR_Y = 3'd1;
	localparam logic [IDX_W-1:0] CFG_ANCHOR_Z = 3'd2;
	localparam logic [IDX_W-1:0] CFG_RADIUS   = 3'd3;
	localparam logic [IDX_W-1:0] CFG_MIN_CONF = 3'd4;
	localparam logic [IDX_W-1:0] CFG_BLEND    = 3'd5;

	typedef logic [3:0] op_t;

	// Datapath operations
	localparam op_t OP_NONE    = 4'd0;
	localparam op_t OP_LOAD    = 4'd1;   // latch item, qualify, clear distance
	localparam op_t OP_SQ_MUL  = 4'd2;   // square one axis difference
	localparam op_t OP_SQ_ACC  = 4'd3;   // add square to distance^2
	localparam op_t OP_SQRT_GO = 4'd4;   // start square root
	localparam op_t OP_DIVW_GO = 4'd5;   // start weight division
	localparam op_t OP_W_MUL   = 4'd6;   // weight * |coordinate|
	localparam op_t OP_W_ACC   = 4'd7;   // saturating add into axis sum
	localparam op_t OP_WT_ACC  = 4'd8;   // saturating add into weight total
	localparam op_t OP_FDIV_GO = 4'd9;   // start |sum| / weight total
	localparam op_t OP_MEAN    = 4'd10;  // clamp mean, form mean - anchor
	localparam op_t OP_B_MUL   = 4'd11;  // blend * |diff|
	localparam op_t OP_B_RES   = 4'd12;  // anchor +/- scaled diff
	localparam op_t OP_OUT     = 4'd13;  // load output register, clear sums

	typedef struct packed {
		op_t        op;
		logic [1:0] axis;
	} cmd_t;

	typedef struct packed {
		logic gate;       // confidence and box test passed
		logic dist_ok;    // root below radius
		logic last;       // item ends the set
		logic wt_zero;    // weight total is zero
		logic sqrt_busy;
		logic div_busy;
		logic out_full;   // result still waiting downstream
	} sts_t;

endpackage

// ===== hdl/weighted_anchor_refine.sv =====
// ----------------------------------------------------------------------------
// weighted_anchor_refine
// Inverse-distance weighted centroid refinement of one anchor point.
// ----------------------------------------------------------------------------
// One vertex item is taken at a time. A vertex that fails the confidence or
// per-axis radius test goes straight on to the last-vertex check. A vertex
// that passes the box test goes on through the squares and the 32-step
// bit-serial square root, and one that also lies inside the radius through
// the 64-step weight division and the three accumulations. A vertex marked
// last then loads the output register without any division when the weight
// total is zero, otherwise after three 64-step mean divisions and the blend.
// A result waits in an output register while the next vertex is taken; a
// later last vertex stalls until it has left. Config writes are taken only
// while the block is idle and no vertex item is offered.
// ----------------------------------------------------------------------------
module weighted_anchor_refine (
	input  logic                      clk,
	input  logic                      arst_n,
	// config write channel
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [war_pkg::IDX_W-1:0] cfg_index,
	input  logic [31:0]               cfg_data,
	// vertex items
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [119:0]              s_tdata,   // vertex_x, vertex_y, vertex_z, vertex_conf
	input  logic                      s_tlast,   // last_vertex
	// refined anchor items
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [95:0]               m_tdata,   // new_x, new_y, new_z
	output logic                      m_tuser    // updated
);

	war_pkg::cmd_t cmd;
	war_pkg::sts_t sts;
	logic          cfg_we;

	// config taken only while idle with no vertex offered
	assign cfg_ready = s_tready && !s_tvalid;
	assign cfg_we    = cfg_valid && cfg_ready;

	war_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	war_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

// ===== hdl/war_sqrt.sv =====
// ----------------------------------------------------------------------------
// war_sqrt
// Bit-serial integer square root: one root bit per cycle, a 32-bit root for a
// 64-bit radicand, floor result.
// ----------------------------------------------------------------------------
module war_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        busy,
	output logic [31:0] root
);

	localparam int STEPS = 32;

	logic [63:0] n_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [5:0]  cnt_q;
	logic [35:0] trial_rem;
	logic [35:0] trial;
	logic        fits;

	// next two radicand bits against 4*root+1
	assign trial_rem = {rem_q, n_q[63:62]};
	assign trial     = {2'b00, root_q, 2'b01};
	assign fits      = trial_rem >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'(STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	// iteration registers
	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			n_q <= {n_q[61:0], 2'b00};
			if (fits) begin
				rem_q  <= 34'(trial_rem - trial);
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= trial_rem[33:0];
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

	assign busy = cnt_q != '0;
	assign root = root_q;

endmodule

// ===== hdl/war_div.sv =====
// ----------------------------------------------------------------------------
// war_div
// Restoring unsigned divider, 64-bit dividend by 40-bit divisor, one
// quotient bit per cycle, 64 quotient bits.
// ----------------------------------------------------------------------------
module war_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [39:0] divisor,
	output logic        busy,
	output logic [63:0] quot
);

	localparam int STEPS = 64;

	logic [63:0] q_q;
	logic [39:0] rem_q;
	logic [39:0] dvs_q;
	logic [6:0]  cnt_q;
	logic [40:0] part;
	logic        fits;

	// shift in the next dividend bit and try the subtract
	assign part = {rem_q, q_q[63]};
	assign fits = part >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 7'(STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			q_q   <= {q_q[62:0], fits};
			rem_q <= fits ? 40'(part - {1'b0, dvs_q}) : part[39:0];
		end
	end

	assign busy = cnt_q != '0;
	assign quot = q_q;

endmodule

// ===== hdl/war_dp.sv =====
// ----------------------------------------------------------------------------
// war_dp
// Datapath: config registers, item latch, shared multiplier, square root and
// divider, saturating sums and the output register.
// ----------------------------------------------------------------------------
module war_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  war_pkg::cmd_t               cmd,
	output war_pkg::sts_t               sts,
	input  logic                        cfg_we,
	input  logic [war_pkg::IDX_W-1:0]   cfg_index,
	input  logic [31:0]                 cfg_data,
	input  logic [119:0]                s_tdata,
	input  logic                        s_tlast,
	input  logic                        m_tready,
	output logic                        m_tvalid,
	output logic [95:0]                 m_tdata,
	output logic                        m_tuser
);

	localparam logic [war_pkg::ACC_W-1:0] ACC_MAX = {1'b0, {(war_pkg::ACC_W-1){1'b1}}};
	localparam logic [war_pkg::ACC_W-1:0] ACC_MIN = {1'b1, {(war_pkg::ACC_W-1){1'b0}}};

	// config registers
	logic [31:0]                  anc_q [3];
	logic [war_pkg::RAD_W-1:0]    rad_q;
	logic [war_pkg::CONF_W-1:0]   minc_q;
	logic [war_pkg::CONF_W-1:0]   bf_q;

	// item latch
	logic [31:0]                  vin_q [3];
	logic [war_pkg::RAD_W-1:0]    mag_q [3];
	logic [war_pkg::CONF_W-1:0]   conf_q;
	logic                         last_q;
	logic                         gate_q;

	// working state
	logic [63:0]                  dsq_q;
	logic [65:0]                  mul_q;
	logic [war_pkg::ACC_W-1:0]    sum_q [3];
	logic [war_pkg::WT_W-1:0]     wt_q;
	logic [32:0]                  diff_q;
	logic [31:0]                  res_q [3];
	logic                         m_valid_q;
	logic [95:0]                  m_data_q;
	logic                         m_user_q;

	logic [31:0]                  vin [3];
	logic [32:0]                  dlt [3];
	logic [32:0]                  dmag [3];
	logic [2:0]                   inbox;
	logic [war_pkg::CONF_W-1:0]   conf_in;
	logic [war_pkg::CONF_W-1:0]   bf_sat;
	logic [war_pkg::MUL_W-1:0]    mul_a;
	logic [war_pkg::MUL_W-1:0]    mul_b;
	logic [31:0]                  vsel;
	logic [32:0]                  vmag;
	logic [war_pkg::W_W-1:0]      wgt;
	logic [63:0]                  psgn;
	logic [64:0]                  ssum;
	logic [war_pkg::ACC_W-1:0]    sat_sum;
	logic [war_pkg::WT_W:0]       wt_sum;
	logic [63:0]                  sum_sel;
	logic [63:0]                  sum_mag;
	logic [31:0]                  mean;
	logic [32:0]                  dmag_b;
	logic [32:0]                  step;

	logic                         sqrt_go;
	logic                         sqrt_busy;
	logic [31:0]                  sq_root;
	logic                         div_go;
	logic                         div_busy;
	logic [63:0]                  div_n;
	logic [39:0]                  div_d;
	logic [63:0]                  quot;

	// incoming coordinates, differences and box test
	assign vin[0] = s_tdata[31:0];
	assign vin[1] = s_tdata[63:32];
	assign vin[2] = s_tdata[95:64];
	assign conf_in = (s_tdata[112:96] > war_pkg::ONE_Q16) ? war_pkg::ONE_Q16
		: s_tdata[112:96];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dlt[k]   = {vin[k][31], vin[k]} - {anc_q[k][31], anc_q[k]};
			dmag[k]  = dlt[k][32] ? 33'(-dlt[k]) : dlt[k];
			inbox[k] = dmag[k] < {2'b00, rad_q};
		end
	end

	assign bf_sat = (bf_q > war_pkg::ONE_Q16) ? war_pkg::ONE_Q16 : bf_q;
	assign wgt    = quot[war_pkg::W_W-1:0];
	assign vsel   = vin_q[cmd.axis];
	assign vmag   = vsel[31] ? 33'(-{1'b1, vsel}) : {1'b0, vsel};
	assign dmag_b = diff_q[32] ? 33'(-diff_q) : diff_q;

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			war_pkg::OP_SQ_MUL: begin
				mul_a = {2'b00, mag_q[cmd.axis]};
				mul_b = {2'b00, mag_q[cmd.axis]};
			end
			war_pkg::OP_W_MUL: begin
				mul_a = {13'd0, wgt};
				mul_b = vmag;
			end
			war_pkg::OP_B_MUL: begin
				mul_a = {16'd0, bf_sat};
				mul_b = dmag_b;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// signed product and saturating sum
	assign psgn    = vsel[31] ? 64'(-mul_q[63:0]) : mul_q[63:0];
	assign ssum    = {sum_q[cmd.axis][63], sum_q[cmd.axis]} + {psgn[63], psgn};
	assign sat_sum = (ssum[64] != ssum[63]) ? (ssum[64] ? ACC_MIN : ACC_MAX) : ssum[63:0];
	assign wt_sum  = {1'b0, wt_q} + (war_pkg::WT_W+1)'(wgt);

	// mean from quotient, clamped to coordinate range
	assign sum_sel = sum_q[cmd.axis];
	assign sum_mag = sum_sel[63] ? 64'(-sum_sel) : sum_sel;
	always_comb begin
		if (!sum_sel[63]) begin
			mean = (quot > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quot[31:0];
		end else begin
			mean = (quot > 64'h8000_0000) ? 32'h8000_0000 : 32'(-quot[31:0]);
		end
	end
	assign step = mul_q[48:16];

	// iterative units
	assign sqrt_go = cmd.op == war_pkg::OP_SQRT_GO;
	assign div_go  = (cmd.op == war_pkg::OP_DIVW_GO) || (cmd.op == war_pkg::OP_FDIV_GO);
	assign div_n   = (cmd.op == war_pkg::OP_FDIV_GO) ? sum_mag : {31'd0, conf_q, 16'd0};
	assign div_d   = (cmd.op == war_pkg::OP_FDIV_GO) ? wt_q
		: 40'({1'b0, sq_root} + {17'd0, war_pkg::TENTH_Q16});

	war_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_go),
		.radicand (dsq_q),
		.busy     (sqrt_busy),
		.root     (sq_root)
	);

	war_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (div_n),
		.divisor  (div_d),
		.busy     (div_busy),
		.quot     (quot)
	);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anc_q[0] <= '0;
			anc_q[1] <= '0;
			anc_q[2] <= '0;
			rad_q    <= 31'd131072;
			minc_q   <= 17'd52429;
			bf_q     <= 17'd19661;
		end else if (cfg_we) begin
			case (cfg_index)
				war_pkg::CFG_ANCHOR_X: anc_q[0] <= cfg_data;
				war_pkg::CFG_ANCHOR_Y: anc_q[1] <= cfg_data;
				war_pkg::CFG_ANCHOR_Z: anc_q[2] <= cfg_data;
				war_pkg::CFG_RADIUS:   rad_q    <= cfg_data[war_pkg::RAD_W-1:0];
				war_pkg::CFG_MIN_CONF: minc_q   <= cfg_data[war_pkg::CONF_W-1:0];
				war_pkg::CFG_BLEND:    bf_q     <= cfg_data[war_pkg::CONF_W-1:0];
				default: ;
			endcase
		end
	end

	// item latch and working payload
	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		case (cmd.op)
			war_pkg::OP_LOAD: begin
				for (int k = 0; k < 3; k++) begin
					vin_q[k] <= vin[k];
					mag_q[k] <= dmag[k][war_pkg::RAD_W-1:0];
				end
				conf_q <= conf_in;
				last_q <= s_tlast;
				gate_q <= (conf_in >= minc_q) && (&inbox);
				dsq_q  <= '0;
			end
			war_pkg::OP_SQ_ACC: dsq_q <= dsq_q + mul_q[63:0];
			war_pkg::OP_MEAN:   diff_q <= {mean[31], mean} - {anc_q[cmd.axis][31], anc_q[cmd.axis]};
			war_pkg::OP_B_RES: begin
				res_q[cmd.axis] <= diff_q[32] ? anc_q[cmd.axis] - step[31:0]
					: anc_q[cmd.axis] + step[31:0];
			end
			default: ;
		endcase
	end

	// sums, weight total, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q[0]  <= '0;
			sum_q[1]  <= '0;
			sum_q[2]  <= '0;
			wt_q      <= '0;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
			m_user_q  <= 1'b0;
		end else begin
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (cmd.op)
				war_pkg::OP_W_ACC:  sum_q[cmd.axis] <= sat_sum;
				war_pkg::OP_WT_ACC: begin
					wt_q <= wt_sum[war_pkg::WT_W] ? {war_pkg::WT_W{1'b1}}
						: wt_sum[war_pkg::WT_W-1:0];
				end
				war_pkg::OP_OUT: begin
					m_valid_q <= 1'b1;
					m_user_q  <= wt_q != '0;
					m_data_q  <= (wt_q == '0) ? {anc_q[2], anc_q[1], anc_q[0]}
						: {res_q[2], res_q[1], res_q[0]};
					sum_q[0]  <= '0;
					sum_q[1]  <= '0;
					sum_q[2]  <= '0;
					wt_q      <= '0;
				end
				default: ;
			endcase
		end
	end

	assign sts.gate      = gate_q;
	assign sts.dist_ok   = {1'b0, sq_root} < {2'b00, rad_q};
	assign sts.last      = last_q;
	assign sts.wt_zero   = wt_q == '0;
	assign sts.sqrt_busy = sqrt_busy;
	assign sts.div_busy  = div_busy;
	assign sts.out_full  = m_valid_q;

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

	// the two iterative units never run together
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(sqrt_busy && div_busy))
		else $error("sqrt and divider busy together");

	// a new item is never latched while the square root or divider runs
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == war_pkg::OP_LOAD) |-> (!div_busy && !sqrt_busy))
		else $error("item loaded while a unit is busy");

	// a result always clears the total and fills the output register
	a_out_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == war_pkg::OP_OUT) |=> (wt_q == '0 && m_valid_q))
		else $error("output did not clear weight total");

	// output is only loaded into an empty register
	a_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == war_pkg::OP_OUT) |-> !m_valid_q)
		else $error("result overwritten");

endmodule

// ===== hdl/war_ctrl.sv =====
// ----------------------------------------------------------------------------
// war_ctrl
// Sequencer: steps one vertex through squaring, root, weight divide and
// accumulation, and on the last vertex, unless the weight total is zero,
// through the per-axis mean and blend.
module war_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  war_pkg::sts_t sts,
	output war_pkg::cmd_t cmd
);

	localparam logic [4:0] ST_IDLE      = 5'd0;
	localparam logic [4:0] ST_CHECK     = 5'd1;
	localparam logic [4:0] ST_SQ_MUL    = 5'd2;
	localparam logic [4:0] ST_SQ_ACC    = 5'd3;
	localparam logic [4:0] ST_SQRT_GO   = 5'd4;
	localparam logic [4:0] ST_SQRT_WAIT = 5'd5;
	localparam logic [4:0] ST_DIVW_GO   = 5'd6;
	localparam logic [4:0] ST_DIVW_WAIT = 5'd7;
	localparam logic [4:0] ST_W_MUL     = 5'd8;
	localparam logic [4:0] ST_W_ACC     = 5'd9;
	localparam logic [4:0] ST_WT_ACC    = 5'd10;
	localparam logic [4:0] ST_LAST      = 5'd11;
	localparam logic [4:0] ST_FDIV_GO   = 5'd12;
	localparam logic [4:0] ST_FDIV_WAIT = 5'd13;
	localparam logic [4:0] ST_MEAN      = 5'd14;
	localparam logic [4:0] ST_B_MUL     = 5'd15;
	localparam logic [4:0] ST_B_RES     = 5'd16;
	localparam logic [4:0] ST_OUT       = 5'd17;

	logic [4:0] state_q;
	logic [4:0] state_d;
	logic [1:0] axis_q;
	logic [1:0] axis_d;

	assign s_tready = state_q == ST_IDLE;

	// next state, axis and command
	always_comb begin
		state_d  = state_q;
		axis_d   = axis_q;
		cmd.op   = war_pkg::OP_NONE;
		cmd.axis = axis_q;
		case (state_q)
			ST_IDLE: begin
				axis_d = 2'd0;
				if (s_tvalid) begin
					cmd.op  = war_pkg::OP_LOAD;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: state_d = sts.gate ? ST_SQ_MUL : ST_LAST;
			ST_SQ_MUL: begin
				cmd.op  = war_pkg::OP_SQ_MUL;
				state_d = ST_SQ_ACC;
			end
			ST_SQ_ACC: begin
				cmd.op = war_pkg::OP_SQ_ACC;
				if (axis_q == 2'd2) begin
					axis_d  = 2'd0;
					state_d = ST_SQRT_GO;
				end else begin
					axis_d  = axis_q + 2'd1;
					state_d = ST_SQ_MUL;
				end
			end
			ST_SQRT_GO: begin
				cmd.op  = war_pkg::OP_SQRT_GO;
				state_d = ST_SQRT_WAIT;
			end
			ST_SQRT_WAIT: begin
				if (!sts.sqrt_busy) begin
					state_d = sts.dist_ok ? ST_DIVW_GO : ST_LAST;
				end
			end
			ST_DIVW_GO: begin
				cmd.op  = war_pkg::OP_DIVW_GO;
				state_d = ST_DIVW_WAIT;
			end
			ST_DIVW_WAIT: if (!sts.div_busy) state_d = ST_W_MUL;
			ST_W_MUL: begin
				cmd.op  = war_pkg::OP_W_MUL;
				state_d = ST_W_ACC;
			end
			ST_W_ACC: begin
				cmd.op = war_pkg::OP_W_ACC;
				if (axis_q == 2'd2) begin
					axis_d  = 2'd0;
					state_d = ST_WT_ACC;
				end else begin
					axis_d  = axis_q + 2'd1;
					state_d = ST_W_MUL;
				end
			end
			ST_WT_ACC: begin
				cmd.op  = war_pkg::OP_WT_ACC;
				state_d = ST_LAST;
			end
			ST_LAST: begin
				axis_d = 2'd0;
				if (!sts.last) begin
					state_d = ST_IDLE;
				end else begin
					state_d = sts.wt_zero ? ST_OUT : ST_FDIV_GO;
				end
			end
			ST_FDIV_GO: begin
				cmd.op  = war_pkg::OP_FDIV_GO;
				state_d = ST_FDIV_WAIT;
			end
			ST_FDIV_WAIT: if (!sts.div_busy) state_d = ST_MEAN;
			ST_MEAN: begin
				cmd.op  = war_pkg::OP_MEAN;
				state_d = ST_B_MUL;
			end
			ST_B_MUL: begin
				cmd.op  = war_pkg::OP_B_MUL;
				state_d = ST_B_RES;
			end
			ST_B_RES: begin
				cmd.op = war_pkg::OP_B_RES;
				if (axis_q == 2'd2) begin
					state_d = ST_OUT;
				end else begin
					axis_d  = axis_q + 2'd1;
					state_d = ST_FDIV_GO;
				end
			end
			ST_OUT: begin
				if (!sts.out_full) begin
					cmd.op  = war_pkg::OP_OUT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= 2'd0;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
		end
	end

endmodule

// ===== dv/tb_weighted_anchor_refine.sv =====
// ----------------------------------------------------------------------------
// tb_weighted_anchor_refine
// Self-checking bench for the weighted anchor refine block. Vertex sets are
// streamed in under several register settings, with random gaps on both
// stream sides. A bit-true predictor computes each refined anchor, and a
// scoreboard compares every result item against it, field by field.
// ----------------------------------------------------------------------------
module tb_weighted_anchor_refine;

	localparam int IDLE_LIMIT = 40000;

	typedef struct {
		logic [31:0] x, y, z;
		logic        upd;
	} anchor_item_t;

	// Predictor plus store of expected refined anchors
	class anchor_scoreboard;
		longint          anc_x, anc_y, anc_z;
		longint unsigned radius, min_conf, blend;
		longint          acc_x, acc_y, acc_z;
		longint unsigned wt_sum;
		anchor_item_t    pending[$];
		int              errors, results, sets_updated;

		function new();
			anc_x = 0; anc_y = 0; anc_z = 0;
			radius = 131072; min_conf = 52429; blend = 19661;
			acc_x = 0; acc_y = 0; acc_z = 0; wt_sum = 0;
			errors = 0; results = 0; sets_updated = 0;
		endfunction

		function void write_reg(logic [war_pkg::IDX_W-1:0] idx, logic [31:0] val);
			case (idx)
				war_pkg::CFG_ANCHOR_X: anc_x = longint'($signed(val));
				war_pkg::CFG_ANCHOR_Y: anc_y = longint'($signed(val));
				war_pkg::CFG_ANCHOR_Z: anc_z = longint'($signed(val));
				war_pkg::CFG_RADIUS:   radius = val[30:0];
				war_pkg::CFG_MIN_CONF: min_conf = val[16:0];
				war_pkg::CFG_BLEND:    blend = val[16:0];
				default: ;
			endcase
		endfunction

		static function longint unsigned mag(longint v);
			return v < 0 ? -v : v;
		endfunction

		// Floor square root, two bits per step
		static function longint unsigned root(longint unsigned n);
			longint unsigned r, b;
			r = 0;
			b = 64'h4000_0000_0000_0000;
			while (b > n) b >>= 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		static function longint add_sat(longint a, longint b);
			logic signed [64:0] s;
			s = 65'(a) + 65'(b);
			if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
			if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
			return longint'(s);
		endfunction

		// Weighted product; operands are bounded so it cannot leave 64 bits
		static function longint scale(longint unsigned w, longint v);
			return longint'(w) * v;
		endfunction

		function logic [31:0] blend_axis(longint a, longint acc, longint unsigned bf);
			longint          mean, diff;
			longint unsigned q;
			mean = acc / longint'(wt_sum);
			if (mean > 64'sd2147483647) mean = 64'sd2147483647;
			if (mean < -64'sd2147483648) mean = -64'sd2147483648;
			diff = mean - a;
			q = (bf * mag(diff)) >> 16;
			return diff < 0 ? 32'(a - longint'(q)) : 32'(a + longint'(q));
		endfunction

		function void note_vertex(logic [31:0] x, y, z, logic [16:0] c, logic last);
			longint          vx, vy, vz;
			longint unsigned conf, ax, ay, az, rdist, w, bf;
			anchor_item_t    e;
			vx = longint'($signed(x));
			vy = longint'($signed(y));
			vz = longint'($signed(z));
			conf = c > 17'd65536 ? 65536 : c;
			if (conf >= min_conf) begin
				ax = mag(vx - anc_x);
				ay = mag(vy - anc_y);
				az = mag(vz - anc_z);
				if (ax < radius && ay < radius && az < radius) begin
					rdist = root(ax * ax + ay * ay + az * az);
					if (rdist < radius) begin
						w = (conf << 16) / (rdist + 6554);
						acc_x = add_sat(acc_x, scale(w, vx));
						acc_y = add_sat(acc_y, scale(w, vy));
						acc_z = add_sat(acc_z, scale(w, vz));
						wt_sum += w;
						if (wt_sum > 64'hFF_FFFF_FFFF) wt_sum = 64'hFF_FFFF_FFFF;
					end
				end
			end
			if (!last) return;
			bf = blend > 65536 ? 65536 : blend;
			if (wt_sum == 0) begin
				e.x = 32'(anc_x); e.y = 32'(anc_y); e.z = 32'(anc_z); e.upd = 1'b0;
			end else begin
				e.x = blend_axis(anc_x, acc_x, bf);
				e.y = blend_axis(anc_y, acc_y, bf);
				e.z = blend_axis(anc_z, acc_z, bf);
				e.upd = 1'b1;
			end
			pending.push_back(e);
			acc_x = 0; acc_y = 0; acc_z = 0; wt_sum = 0;
		endfunction

		function void check_result(logic [95:0] d, logic upd);
			anchor_item_t e;
			results++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result x=%h y=%h z=%h updated=%b",
					$time, d[31:0], d[63:32], d[95:64], upd);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (e.upd) sets_updated++;
			if (d[31:0] !== e.x) begin
				$display("%0t: new_x expected %h actual %h", $time, e.x, d[31:0]);
				errors++;
			end
			if (d[63:32] !== e.y) begin
				$display("%0t: new_y expected %h actual %h", $time, e.y, d[63:32]);
				errors++;
			end
			if (d[95:64] !== e.z) begin
				$display("%0t: new_z expected %h actual %h", $time, e.z, d[95:64]);
				errors++;
			end
			if (upd !== e.upd) begin
				$display("%0t: updated expected %b actual %b", $time, e.upd, upd);
				errors++;
			end
		endfunction
	endclass

	logic                      clk, arst_n;
	logic                      cfg_valid, cfg_ready;
	logic [war_pkg::IDX_W-1:0] cfg_index;
	logic [31:0]               cfg_data;
	logic                      s_tvalid, s_tready, s_tlast;
	logic [119:0]              s_tdata;
	logic                      m_tvalid, m_tready, m_tuser;
	logic [95:0]               m_tdata;

	anchor_scoreboard sb;
	int src_idle, snk_idle;
	int vertices_sent;
	int idle_cycles = 0;

	weighted_anchor_refine dut (.*);

	// Clock and reset
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Receiver backpressure
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= ($urandom_range(0, 99) >= snk_idle);
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
	end

	// Watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("timeout: no item accepted in %0d cycles", IDLE_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic write_reg(logic [war_pkg::IDX_W-1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic setup(logic [31:0] ax, ay, az, rad, mc, bf);
		write_reg(war_pkg::CFG_ANCHOR_X, ax);
		write_reg(war_pkg::CFG_ANCHOR_Y, ay);
		write_reg(war_pkg::CFG_ANCHOR_Z, az);
		write_reg(war_pkg::CFG_RADIUS, rad);
		write_reg(war_pkg::CFG_MIN_CONF, mc);
		write_reg(war_pkg::CFG_BLEND, bf);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_vertex(logic [31:0] x, y, z, logic [16:0] c, logic last);
		while ($urandom_range(0, 99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, c, z, y, x};
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_vertex(x, y, z, c, last);
		vertices_sent++;
		@(negedge clk);
	endtask

	// Hold the sender until every result is back, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	// Coordinate near the anchor on one axis, sometimes just past the radius
	function automatic logic [31:0] near(longint a);
		longint span, off;
		span = sb.radius + sb.radius / 4 + 1;
		if (span > 64'd1073741824) span = 64'd1073741824;
		off = longint'($urandom_range(0, 32'(2 * span))) - span;
		return 32'(a + off);
	endfunction

	function automatic logic [16:0] pick_conf();
		case ($urandom_range(0, 5))
			0: return 17'($urandom);
			1: return 17'd65536;
			default: return 17'($urandom_range(32768, 65536));
		endcase
	endfunction

	function automatic logic [31:0] pick_radius();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return 32'h7FFF_FFFF;
			2: return 32'd131072;
			3: return $urandom;
			default: return $urandom_range(1, 32'h0010_0000);
		endcase
	endfunction

	function automatic logic [31:0] pick_level();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'd65536;
			2: return 32'($urandom_range(65537, 131071));
			default: return $urandom_range(0, 65536);
		endcase
	endfunction

	function automatic logic [31:0] pick_anchor();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom;
			default: return 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
		endcase
	endfunction

	// One random phase: fresh settings, then sets of mostly well-formed vertices
	task automatic random_phase(int n);
		int k, len;
		setup(pick_anchor(), pick_anchor(), pick_anchor(), pick_radius(),
			pick_level(), pick_level());
		k = 0;
		while (k < n) begin
			len = $urandom_range(1, 7);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 9) < 8)
					send_vertex(near(sb.anc_x), near(sb.anc_y), near(sb.anc_z),
						pick_conf(), i == len - 1);
				else
					send_vertex($urandom, $urandom, $urandom, 17'($urandom), i == len - 1);
				k++;
			end
		end
		drain();
	endtask

	initial begin
		sb = new();
		cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0;
		vertices_sent = 0;
		src_idle = 36; snk_idle = 57;
		@(posedge arst_n);
		@(negedge clk);

		// Directed: default settings, anchor at the origin
		send_vertex(32'd0, 32'd0, 32'd0, 17'd65536, 1'b1);        // vertex on the anchor
		send_vertex(32'd0, 32'd0, 32'd0, 17'd52428, 1'b1);        // confidence just short: empty
		send_vertex(32'd65536, 32'd0, 32'd0, 17'd52429, 1'b0);    // confidence at the minimum
		send_vertex(32'd131072, 32'd0, 32'd0, 17'd65536, 1'b0);   // axis at the radius
		send_vertex(32'd131071, 32'd0, 32'd0, 17'h1FFFF, 1'b0);   // confidence above one
		send_vertex(32'd100000, 32'd100000, 32'd0, 17'd65536, 1'b1); // box ok, too far
		send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 17'd65536, 1'b0);
		send_vertex(32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_FFFF, 17'd60000, 1'b1);
		drain();
		// Zero radius, minimum above one, blend extremes
		setup(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd65536);
		send_vertex(32'd0, 32'd0, 32'd0, 17'd65536, 1'b1);
		drain();
		setup(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'h7FFF_FFFF, 32'd65537, 32'h1FFFF);
		send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 17'd65536, 1'b1);
		drain();
		setup(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'h1FFFF);
		send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 17'd65536, 1'b0);
		send_vertex(32'h7FFF_0000, 32'h8000_1000, 32'd0, 17'd1, 1'b0);
		send_vertex(32'h0000_0000, 32'h0000_0000, 32'h1234_5678, 17'd0, 1'b1);
		drain();
		setup(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 32'h0004_0000, 32'd0, 32'd0);
		send_vertex(32'h0002_0000, 32'hFFFE_0000, 32'h0001_8000, 17'd65536, 1'b0);
		send_vertex(32'h0000_0000, 32'h0000_0000, 32'h0002_0000, 17'd40000, 1'b1);
		drain();

		// Random phases under the three idling patterns
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin src_idle = 36; snk_idle = 57; end
				1: begin src_idle = 57; snk_idle = 36; end
				default: begin src_idle = 0; snk_idle = 0; end
			endcase
			for (int p = 0; p < 3; p++) random_phase(55);
		end

		if (sb.pending.size() != 0) begin
			$display("%0d expected results never arrived", sb.pending.size());
			sb.errors++;
		end
		$display("run covered %0d vertices, %0d results (%0d refined), over 14 settings",
			vertices_sent, sb.results, sb.sets_updated);
		$display("with three idling patterns on both stream sides, %0d mismatches",
			sb.errors);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/war_pkg.sv
hdl/war_sqrt.sv
hdl/war_div.sv
hdl/war_dp.sv
hdl/war_ctrl.sv
hdl/weighted_anchor_refine.sv
dv/tb_weighted_anchor_refine.sv
